// ----- sv/cdq_pkg.sv -----
// Shared types and constants for the circular deque.
package cdq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_REAR  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_REAR   = 3'd3,
        MODE_PEEK_FRONT = 3'd4,
        MODE_PEEK_REAR  = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
    } t_rsp;

endpackage

// ----- sv/circular_deque.sv -----
// Flow: a request accepted while the sequencer is idle moves it to ST_READ, where the
//   registered read of the slot memory lands; the result passes to the output register
//   once that is free, and no new request is taken until the result has moved on.
// A waiting result does not block the next request, which is worked and then held.
// Reset (synchronous, i_rst_n low) empties the deque and drops any pending result;
//   slot contents are left as they are and need no clearing pass.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_rsp
);

    localparam int IDX_W = $clog2(DEPTH);

    // Slot memory port
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // Result handoff from the sequencer into the output register
    logic rsp_valid;
    logic rsp_free;
    t_rsp rsp;

    // Output register
    logic r_out_valid, n_out_valid;
    t_rsp r_out_rsp, n_out_rsp;

    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_req       (i_in_req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_free  (rsp_free),
        .o_rsp       (rsp),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // The output register can take a new result when empty or being drained
    assign rsp_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_rsp   = r_out_rsp;
        if (rsp_free) begin
            // Advance the finished result, or drop the valid once it is taken
            n_out_valid = rsp_valid;
            if (rsp_valid) begin
                n_out_rsp = rsp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Payload holds without reset
    always_ff @(posedge i_clk) begin
        r_out_rsp <= n_out_rsp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

// ----- sv/cdq_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/cdq_ctrl.sv -----
// Deque sequencer: front index, fill count, slot addressing and result forming.
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    output logic                     o_req_ready,
    input  t_req                     i_req,
    output logic                     o_rsp_valid,
    input  logic                     i_rsp_free,
    output t_rsp                     o_rsp,
    output logic                     o_ram_we,
    output logic [$clog2(DEPTH)-1:0] o_ram_waddr,
    output logic [DATA_W-1:0]        o_ram_wdata,
    output logic                     o_ram_re,
    output logic [$clog2(DEPTH)-1:0] o_ram_raddr,
    input  logic [DATA_W-1:0]        i_ram_rdata
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = $clog2(2 * DEPTH);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_use_rd, n_use_rd;
    t_status            r_status, n_status;

    logic               full, empty;
    logic [IDX_W-1:0]   head_dec, head_inc, rear_wr, rear_rd;
    logic [SUM_W-1:0]   sum_wr, sum_rd;
    logic [CNT_W+COUNT_W-1:0] cnt_ext;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // Ring neighbors of the front slot
    assign head_dec = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Rear slots: sums stay below twice the depth, so one subtract wraps them
    assign sum_wr  = SUM_W'(r_head) + SUM_W'(r_count);
    assign sum_rd  = sum_wr - 1'b1;
    assign rear_wr = (sum_wr >= SUM_W'(DEPTH)) ? IDX_W'(sum_wr - SUM_W'(DEPTH))
                                               : IDX_W'(sum_wr);
    assign rear_rd = (sum_rd >= SUM_W'(DEPTH)) ? IDX_W'(sum_rd - SUM_W'(DEPTH))
                                               : IDX_W'(sum_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_use_rd <= 1'b0;
            r_status <= STATUS_DONE;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_use_rd <= n_use_rd;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_use_rd    = r_use_rd;
        n_status    = r_status;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_head;
        o_ram_wdata = i_req.value;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_head;
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_state  = ST_READ;
                    n_use_rd = 1'b0;
                    n_status = STATUS_DONE;
                    case (t_mode'(i_req.mode))
                        MODE_PUSH_FRONT: begin
                            if (full) begin
                                n_status = STATUS_FULL;
                            end else begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = head_dec;
                                n_head      = head_dec;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        MODE_PUSH_REAR: begin
                            if (full) begin
                                n_status = STATUS_FULL;
                            end else begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = rear_wr;
                                n_count     = r_count + 1'b1;
                            end
                        end
                        MODE_POP_FRONT, MODE_PEEK_FRONT: begin
                            if (empty) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = r_head;
                                n_use_rd    = 1'b1;
                                if (t_mode'(i_req.mode) == MODE_POP_FRONT) begin
                                    n_head  = head_inc;
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        MODE_POP_REAR, MODE_PEEK_REAR: begin
                            if (empty) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = rear_rd;
                                n_use_rd    = 1'b1;
                                if (t_mode'(i_req.mode) == MODE_POP_REAR) begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                // Read data is held by the RAM until the next read is issued
                o_rsp_valid = 1'b1;
                if (i_rsp_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign cnt_ext = {{COUNT_W{1'b0}}, r_count};

    assign o_rsp.data   = r_use_rd ? i_ram_rdata : '0;
    assign o_rsp.status = r_status;
    assign o_rsp.count  = cnt_ext[COUNT_W-1:0];

endmodule
